// ----- rtl/stsu_pkg.sv -----
package stsu_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int HALF_SHIFT  = 29 - SAMPLE_BITS;

    localparam logic signed [31:0] K_ENV   = 32'sd107374182;
    localparam logic signed [31:0] K_173   = 32'sd1857573356;
    localparam logic signed [31:0] K_122   = 32'sd1309965025;
    localparam logic signed [31:0] K_REAR  = 32'sd730144440;
    localparam logic signed [31:0] K_CLAMP = 32'sd966367642;
    localparam logic signed [31:0] Q_ONE   = 32'sd1073741824;

    localparam logic [31:0] G_FRONT  = 32'd3435973837;
    localparam logic [31:0] G_CENTER = 32'd3221225472;
    localparam logic [31:0] G_SIDE   = 32'd3865470566;
    localparam logic [31:0] G_ADD    = 32'd858993459;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } stsu_in_t;

    typedef struct packed {
        logic signed [31:0] front_left;
        logic signed [31:0] front_right;
        logic signed [31:0] center_out;
        logic signed [31:0] lfe_out;
        logic signed [31:0] rear_left;
        logic signed [31:0] rear_right;
    } stsu_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7fffffff;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage

// ----- rtl/stsu_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Computes trunc(num * 2^30 / den) saturated to 32 bits, den > 0.
module stsu_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    import stsu_pkg::*;

    logic [61:0] dvd_reg, dvd_next;
    logic [61:0] q_reg, q_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] mag;
    logic signed [65:0] sq;

    assign trial = {rem_reg, dvd_reg[61]};
    assign diff  = trial - {1'b0, den_reg};
    assign mag   = num[31] ? 32'(-num) : num;

    always_comb begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = {mag, 30'd0};
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'd0;
            neg_next  = num[31];
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[60:0], 1'b0};
            if (!diff[32]) begin
                rem_next = diff[31:0];
                q_next   = {q_reg[60:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                q_next   = {q_reg[60:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd61) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign sq   = neg_reg ? -$signed({4'd0, q_reg}) : $signed({4'd0, q_reg});
    assign quo  = sat32(sq);
    assign done = done_reg;

endmodule

// ----- rtl/stereo_to_surround_upmix.sv -----
// Stereo to 5.1 matrix upmix.
// Input channel s_: one word holds a signed left/right sample pair.
// Output channel m_: one word holds six 32-bit saturated outputs, in the
// order front left, front right, center, LFE, rear left, rear right.
// The 16-bit form of each output is its upper half.
// One word is worked on at a time. After the accepting edge the envelope
// followers update (ST_ENV, then ST_ACC), two divisions that share one
// restoring divider giving one quotient bit a cycle run in sequence, 17
// multiply steps go through a single shared multiplier, and then the
// output register is loaded once it is free, which raises m_valid.
// The two divisions take most of the time spent on each word.
// Reset (aresetn low, synchronous) clears both envelopes to zero and
// empties the output register.
// When the receiver stalls, the result holds in the output register while
// the next word is taken in and worked on; a finished word that finds the
// output register still full waits, with s_ready low, until it is taken.
module stereo_to_surround_upmix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stsu_pkg::stsu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stsu_pkg::stsu_out_t m_data
);
    import stsu_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_ENV  = 8'b00000010,
        ST_ACC  = 8'b00000100,
        ST_DIVL = 8'b00001000,
        ST_DIVR = 8'b00010000,
        ST_MUL  = 8'b00100000,
        ST_OUT  = 8'b01000000,
        ST_WAIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] c_reg, sl_reg, sr_reg;
    logic signed [31:0] lenv_reg, renv_reg;
    logic signed [31:0] front_reg, rear_reg;
    logic signed [31:0] vl_reg, vr_reg;
    logic signed [31:0] t_reg [0:7];
    logic [4:0]         step_reg;
    logic               dstart;
    logic               ddone;
    logic signed [31:0] dnum, dden, dquo;
    stsu_out_t          res_reg;
    stsu_out_t          out_reg;
    logic               ovalid_reg;
    logic               load_out;

    logic signed [SAMPLE_BITS:0] lsum, ldif;
    logic signed [31:0] bal, bc;

    // shared multiplier operands
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [31:0] qm;
    logic signed [31:0] so;

    assign lsum = s_data.left_sample + s_data.right_sample;
    assign ldif = s_data.left_sample - s_data.right_sample;
    // balance of the two envelopes, held steady while the divider runs
    assign bal = sat32(66'(renv_reg) - 66'(lenv_reg));
    assign bc = (bal > K_CLAMP) ? K_CLAMP :
                ((bal < -K_CLAMP) ? -K_CLAMP : bal);

    assign dnum = (state_reg == ST_DIVL) ? sl_reg : sr_reg;
    assign dden = (state_reg == ST_DIVL) ? 32'(Q_ONE - bc) : 32'(Q_ONE + bc);

    stsu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dstart),
        .num     (dnum),
        .den     (dden),
        .done    (ddone),
        .quo     (dquo)
    );

    logic started_reg;
    assign dstart = ((state_reg == ST_DIVL) || (state_reg == ST_DIVR)) && !started_reg;

    // multiply schedule: select operands per step
    always_comb begin
        ma = '0;
        mb = '0;
        case (step_reg)
            5'd0:  begin ma = 33'(sl_reg);   mb = 33'(front_reg); end
            5'd1:  begin ma = 33'(sr_reg);   mb = 33'(front_reg); end
            5'd2:  begin ma = 33'(vr_reg);   mb = 33'(K_173);     end
            5'd3:  begin ma = 33'(vl_reg);   mb = 33'(K_122);     end
            5'd4:  begin ma = 33'(vr_reg);   mb = 33'(K_122);     end
            5'd5:  begin ma = 33'(vl_reg);   mb = 33'(K_173);     end
            5'd6:  begin ma = 33'(t_reg[6]); mb = 33'(K_REAR);    end
            5'd7:  begin ma = 33'(t_reg[7]); mb = 33'(K_REAR);    end
            5'd8:  begin ma = 33'(t_reg[6]); mb = 33'(rear_reg);  end
            5'd9:  begin ma = 33'(t_reg[7]); mb = 33'(rear_reg);  end
            5'd10: begin ma = 33'(c_reg);    mb = {1'b0, G_ADD};    end
            5'd11: begin ma = 33'(t_reg[0]); mb = {1'b0, G_FRONT};  end
            5'd12: begin ma = 33'(t_reg[1]); mb = {1'b0, G_FRONT};  end
            5'd13: begin ma = 33'(c_reg);    mb = {1'b0, G_CENTER}; end
            5'd14: begin ma = 33'(c_reg);    mb = {1'b0, G_SIDE};   end
            5'd15: begin ma = 33'(t_reg[6]); mb = {1'b0, G_SIDE};   end
            5'd16: begin ma = 33'(t_reg[7]); mb = {1'b0, G_SIDE};   end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = ma * mb;
    // round half up, floor
    logic signed [65:0] prnd;
    assign prnd = prod + 66'sd536870912;
    assign qm = sat32(prnd >>> 30);
    // truncate toward zero
    logic signed [65:0] ptr;
    assign ptr = prod[65] ? (prod + 66'sd1073741823) : prod;
    assign so = sat32(ptr >>> 30);

    // envelope update: register the step toward the side level, then scale and accumulate it
    logic signed [31:0] absl, absr, dl, dr, ql, qr;
    logic signed [31:0] dl_reg, dr_reg;
    logic signed [65:0] pl, pr;
    assign absl = sl_reg[31] ? sat32(-66'(sl_reg)) : sl_reg;
    assign absr = sr_reg[31] ? sat32(-66'(sr_reg)) : sr_reg;
    assign dl = sat32(66'(absl) - 66'(lenv_reg));
    assign dr = sat32(66'(absr) - 66'(renv_reg));
    assign pl = dl_reg * K_ENV;
    assign pr = dr_reg * K_ENV;
    assign ql = sat32((pl + 66'sd536870912) >>> 30);
    assign qr = sat32((pr + 66'sd536870912) >>> 30);

    // load the output register once it is empty or being taken
    assign load_out = ((state_reg == ST_OUT) || (state_reg == ST_WAIT)) &&
                      (!ovalid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_ENV;
            ST_ENV:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_DIVL;
            ST_DIVL: if (ddone) state_next = ST_DIVR;
            ST_DIVR: if (ddone) state_next = ST_MUL;
            ST_MUL:  if (step_reg == 5'd16) state_next = ST_OUT;
            ST_OUT:  state_next = load_out ? ST_IDLE : ST_WAIT;
            ST_WAIT: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lenv_reg    <= '0;
            renv_reg    <= '0;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_reg    <= res_reg;
                ovalid_reg <= 1'b1;
            end else if (m_ready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    // capture samples, form center and sides (exact)
                    c_reg  <= 32'(lsum) <<< HALF_SHIFT;
                    sl_reg <= 32'(ldif) <<< HALF_SHIFT;
                    sr_reg <= (-32'(ldif)) <<< HALF_SHIFT;
                    step_reg <= '0;
                end
                ST_ENV: begin
                    dl_reg <= dl;
                    dr_reg <= dr;
                end
                ST_ACC: begin
                    lenv_reg <= sat32(66'(lenv_reg) + 66'(ql));
                    renv_reg <= sat32(66'(renv_reg) + 66'(qr));
                end
                ST_DIVL: begin
                    started_reg <= !ddone;
                    if (ddone) vl_reg <= dquo;
                    front_reg <= bal[31] ? sat32(-66'(bal)) : bal;
                end
                ST_DIVR: begin
                    started_reg <= !ddone;
                    if (ddone) vr_reg <= dquo;
                    rear_reg <= sat32(66'(Q_ONE) - 66'(front_reg));
                end
                ST_MUL: begin
                    step_reg <= step_reg + 5'd1;
                    case (step_reg)
                        5'd0, 5'd1, 5'd2, 5'd3, 5'd4: t_reg[step_reg[2:0]] <= qm;
                        5'd5: begin
                            // form rear differences
                            t_reg[6] <= sat32(66'(t_reg[2]) - 66'(t_reg[3]));
                            t_reg[7] <= sat32(66'(t_reg[4]) - 66'(qm));
                        end
                        // refine rear terms in place
                        5'd6, 5'd8: t_reg[6] <= qm;
                        5'd7, 5'd9: t_reg[7] <= qm;
                        5'd10: t_reg[5] <= so;
                        5'd11: res_reg.front_left
                                   <= sat32(66'(so) + 66'(t_reg[5]));
                        5'd12: res_reg.front_right
                                   <= sat32(66'(so) + 66'(t_reg[5]));
                        5'd13: res_reg.center_out <= so;
                        5'd14: res_reg.lfe_out    <= so;
                        5'd15: res_reg.rear_left  <= so;
                        5'd16: res_reg.rear_right <= so;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;

endmodule

// ----- test/stereo_to_surround_upmix_tb.sv -----
module stereo_to_surround_upmix_tb;
    import stsu_pkg::*;

    localparam int  RANDOM_WORDS = 1230;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 200;

    // Q30 constants and output gains of the upmix matrix.
    localparam longint Q30_ONE   = 64'sd1073741824;
    localparam longint ENV_COEF  = 64'sd107374182;
    localparam longint W_173     = 64'sd1857573356;
    localparam longint W_122     = 64'sd1309965025;
    localparam longint W_REAR    = 64'sd730144440;
    localparam longint BAL_LIMIT = 64'sd966367642;
    localparam longint GAIN_FRONT  = 64'sd3435973837;
    localparam longint GAIN_CENTER = 64'sd3221225472;
    localparam longint GAIN_SIDE   = 64'sd3865470566;
    localparam longint GAIN_ADD    = 64'sd858993459;

    // Predicts the 5.1 frame for each accepted stereo word and holds the
    // frames still owed by the block.
    class upmix_scoreboard;
        longint    env_left;
        longint    env_right;
        stsu_out_t frames_owed[$];

        function new();
            env_left  = 0;
            env_right = 0;
        endfunction

        static function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        static function longint mag32(longint x);
            return x < 0 ? clip32(-x) : x;
        endfunction

        // Round half up, then saturate.
        static function longint q30_mul(longint a, longint b);
            return clip32((a * b + 64'sd536870912) >>> 30);
        endfunction

        static function longint q30_div(longint num, longint den);
            return clip32((num * Q30_ONE) / den);
        endfunction

        static function longint scale(longint q, longint gain);
            return clip32((q * gain) / Q30_ONE);
        endfunction

        function void note_input(stsu_in_t w);
            longint l, r, ctr, side_l, side_r, bal, front, rear, bc;
            longint vl, vr, mix_l, mix_r, cx;
            stsu_out_t f;
            l = longint'(w.left_sample);
            r = longint'(w.right_sample);
            ctr    = clip32((l + r) * (64'sd1 << HALF_SHIFT));
            side_l = clip32((l - r) * (64'sd1 << HALF_SHIFT));
            side_r = clip32((r - l) * (64'sd1 << HALF_SHIFT));

            env_left  = clip32(env_left + q30_mul(clip32(mag32(side_l) - env_left), ENV_COEF));
            env_right = clip32(env_right +
                               q30_mul(clip32(mag32(side_r) - env_right), ENV_COEF));

            bal   = clip32(env_right - env_left);
            front = mag32(bal);
            rear  = clip32(Q30_ONE - front);
            bc    = bal > BAL_LIMIT ? BAL_LIMIT : (bal < -BAL_LIMIT ? -BAL_LIMIT : bal);

            vl = q30_div(side_l, Q30_ONE - bc);
            vr = q30_div(side_r, Q30_ONE + bc);

            mix_l = clip32(q30_mul(vr, W_173) - q30_mul(vl, W_122));
            mix_r = clip32(q30_mul(vr, W_122) - q30_mul(vl, W_173));
            mix_l = q30_mul(q30_mul(mix_l, W_REAR), rear);
            mix_r = q30_mul(q30_mul(mix_r, W_REAR), rear);

            cx = scale(ctr, GAIN_ADD);
            f.front_left  = 32'(clip32(scale(q30_mul(side_l, front), GAIN_FRONT) + cx));
            f.front_right = 32'(clip32(scale(q30_mul(side_r, front), GAIN_FRONT) + cx));
            f.center_out  = 32'(scale(ctr, GAIN_CENTER));
            f.lfe_out     = 32'(scale(ctr, GAIN_SIDE));
            f.rear_left   = 32'(scale(mix_l, GAIN_SIDE));
            f.rear_right  = 32'(scale(mix_r, GAIN_SIDE));
            frames_owed.push_back(f);
        endfunction

        // Return an empty string when the frame matches, else what differs.
        function string check(stsu_out_t got);
            stsu_out_t want;
            string     msg;
            msg = "";
            if (frames_owed.size() == 0) return "frame with no word outstanding";
            want = frames_owed.pop_front();
            if (got.front_left != want.front_left)
                msg = {msg, $sformatf(" FL %0d/%0d", got.front_left, want.front_left)};
            if (got.front_right != want.front_right)
                msg = {msg, $sformatf(" FR %0d/%0d", got.front_right, want.front_right)};
            if (got.center_out != want.center_out)
                msg = {msg, $sformatf(" C %0d/%0d", got.center_out, want.center_out)};
            if (got.lfe_out != want.lfe_out)
                msg = {msg, $sformatf(" LFE %0d/%0d", got.lfe_out, want.lfe_out)};
            if (got.rear_left != want.rear_left)
                msg = {msg, $sformatf(" RL %0d/%0d", got.rear_left, want.rear_left)};
            if (got.rear_right != want.rear_right)
                msg = {msg, $sformatf(" RR %0d/%0d", got.rear_right, want.rear_right)};
            return msg;
        endfunction

        function int pending();
            return frames_owed.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    stsu_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    stsu_out_t m_data;

    upmix_scoreboard sb;
    int  mismatches = 0;
    int  frames_seen = 0;
    int  cycles = 0;
    bit  steady;    // high: neither side idles

    stereo_to_surround_upmix dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Report one mismatch on one line and count it.
    task automatic report(string msg);
        $display("mismatch at frame %0d:%s", frames_seen, msg);
        mismatches++;
    endtask

    // Watch both channels; note each accepted word, check each frame.
    always @(posedge aclk) begin
        string msg;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) begin
                msg = sb.check(m_data);
                if (msg != "") report(msg);
                frames_seen++;
            end
        end
    end

    // Stall the receiver about one cycle in five, except in steady stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
        end
    end

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drive one word: maybe idle first, then hold valid until accepted.
    // Valid stays high into the next word when no idle gap is drawn.
    task automatic send_word(stsu_in_t w);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 20) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pair(int l, int r);
        stsu_in_t w;
        w.left_sample  = l[SAMPLE_BITS-1:0];
        w.right_sample = r[SAMPLE_BITS-1:0];
        send_word(w);
    endtask

    // Drop valid and hold until every frame owed has come out.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Draw one sample pair in the given flavor.
    task automatic random_pair(int flavor);
        int big, tiny;
        big  = $urandom_range(0, 65535) - 32768;
        tiny = $urandom_range(0, 512) - 256;
        case (flavor)
            0: send_pair($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            1: send_pair(big, tiny);                       // hard left pan
            2: send_pair(tiny, big);                       // hard right pan
            3: send_pair(tiny, $urandom_range(0, 512) - 256);
            4: send_pair($urandom_range(1) ? 32767 : -32768,
                         $urandom_range(1) ? 32767 : -32768);
            default: send_pair(big, -big);                 // anti-phase
        endcase
    endtask

    initial begin
        int left_to_send, run, flavor;
        sb          = new();
        steady      = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zeros, full-scale corners, and sustained anti-phase runs of
        // each sign, which drive both envelopes up together.
        send_pair(0, 0);
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(32767, -32768);
        send_pair(-32768, 32767);
        send_pair(1, -1);
        send_pair(-1, 0);
        repeat (8) send_pair(32767, -32768);
        repeat (8) send_pair(-32768, 32767);
        send_pair(0, 0);
        drain();

        // Random: runs of one flavor so the envelopes settle.
        left_to_send = RANDOM_WORDS;
        while (left_to_send > 0) begin
            if (left_to_send < RANDOM_WORDS * 3 / 4 && left_to_send > RANDOM_WORDS / 2)
                steady = 1'b1;
            else
                steady = 1'b0;
            flavor = $urandom_range(0, 5);
            run    = $urandom_range(10, 60);
            if (run > left_to_send) run = left_to_send;
            repeat (run) random_pair(flavor);
            left_to_send -= run;
            if ($urandom_range(9) == 0) drain();
        end
        steady = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/stsu_pkg.sv
rtl/stsu_div.sv
rtl/stereo_to_surround_upmix.sv
test/stereo_to_surround_upmix_tb.sv
